@@ hdl/ahkp_pkg.sv @@
// Shared types, constants and character decode functions for the hex key report parser.
package ahkp_pkg;

    localparam logic [7:0] LineFeed       = 8'd10;
    localparam logic [7:0] CarriageReturn = 8'd13;

    // The last counted character of a report is at this position; counting it completes a report.
    localparam logic [4:0] LastPos   = 5'd22;
    localparam int         SlotCount = 7;
    localparam int         StoredSlots = SlotCount - 1;

    localparam logic [2:0] SlotNone = 3'd7;

    typedef logic [7:0] byte_t;

    // Index 0 is the modifier and indexes 1 to 6 are the key slots.
    typedef byte_t [SlotCount-1:0] report_t;

    // Bit 4 is set when the character is not a hex digit, and bits 3:0 hold the digit value.
    function automatic logic [4:0] hex_value(input byte_t c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic byte_t pair_value(input byte_t hi, input byte_t lo);
        logic [4:0] h;
        logic [4:0] l;
        byte_t      v;
        h = hex_value(hi);
        l = hex_value(lo);
        if (h[4])
        begin
            v = 8'h00;
        end
        else if (l[4])
        begin
            v = {4'h0, h[3:0]};
        end
        else
        begin
            v = {h[3:0], l[3:0]};
        end
        return v;
    endfunction

    function automatic logic is_first_of_pair(input logic [4:0] p);
        logic r;
        case (p)
            5'd0, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] second_slot(input logic [4:0] p);
        logic [2:0] s;
        case (p)
            5'd1:  s = 3'd0;
            5'd7:  s = 3'd1;
            5'd10: s = 3'd2;
            5'd13: s = 3'd3;
            5'd16: s = 3'd4;
            5'd19: s = 3'd5;
            5'd22: s = 3'd6;
            default: s = SlotNone;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/ascii_hex_key_report_parser.sv @@
// Top level of the hex key report parser: input register, report state and result register.
//
// Timing: an accepted byte is held in the input register and parsed from there; the result of
// the byte that completes a report is held in the result register, which drives out_valid.
// Throughput: one request per cycle. Only a byte that completes a report can be held back,
// and only while the result register still holds an untaken result and out_stall is high.
// Reset (rst_n, asynchronous, active low) clears the count, skip mode, pending digit,
// decoded bytes and both valid flags.
module ascii_hex_key_report_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] modifier_bits,
    output logic [7:0] key_slot_0,
    output logic [7:0] key_slot_1,
    output logic [7:0] key_slot_2,
    output logic [7:0] key_slot_3,
    output logic [7:0] key_slot_4,
    output logic [7:0] key_slot_5
);

    // Input register: one received request waiting to be parsed.
    logic            s1_valid_reg;
    ahkp_pkg::byte_t s1_byte_reg;

    // Result register: one completed report waiting to be taken downstream.
    logic              out_valid_reg;
    ahkp_pkg::report_t out_data_reg;

    logic              emit;
    logic              advance;
    logic              emit_fire;
    ahkp_pkg::report_t report;

    // The parse step may proceed unless it completes a report while the result
    // register is full and not being drained this cycle.
    assign advance   = !emit || !out_valid_reg || !out_stall;
    assign emit_fire = s1_valid_reg && emit && advance;
    assign in_stall  = s1_valid_reg && !advance;

    ahkp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s1_valid_reg),
        .advance    (advance),
        .rx_byte    (s1_byte_reg),
        .emit       (emit),
        .report     (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // The received byte is payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= report;
        end
    end

    assign out_valid     = out_valid_reg;
    assign modifier_bits = out_data_reg[0];
    assign key_slot_0    = out_data_reg[1];
    assign key_slot_1    = out_data_reg[2];
    assign key_slot_2    = out_data_reg[3];
    assign key_slot_3    = out_data_reg[4];
    assign key_slot_4    = out_data_reg[5];
    assign key_slot_5    = out_data_reg[6];

    // The input side is held back only by a full result register that is itself stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // A completed report is always presented in the following cycle.
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid_reg)
        else $error("completed report did not reach the result register");

endmodule

@@ hdl/ahkp_core.sv @@
// Report state: character count, skip flag, pending high digit and decoded slot bytes.
module ahkp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              advance,
    input  ahkp_pkg::byte_t   rx_byte,
    output logic              emit,
    output ahkp_pkg::report_t report
);

    logic [4:0]      pos_reg;
    logic [4:0]      pos_next;
    logic            skip_reg;
    logic            skip_next;
    ahkp_pkg::byte_t pending_reg;
    ahkp_pkg::byte_t pending_next;
    ahkp_pkg::byte_t [ahkp_pkg::StoredSlots-1:0] dec_reg;
    ahkp_pkg::byte_t [ahkp_pkg::StoredSlots-1:0] dec_next;

    logic            counted;
    logic [2:0]      slot;
    ahkp_pkg::byte_t pair;
    logic            step;

    assign counted = byte_valid && (rx_byte != ahkp_pkg::LineFeed)
                     && (rx_byte != ahkp_pkg::CarriageReturn) && !skip_reg;
    assign slot    = ahkp_pkg::second_slot(pos_reg);
    assign pair    = ahkp_pkg::pair_value(pending_reg, rx_byte);
    assign emit    = counted && (pos_reg == ahkp_pkg::LastPos);
    assign step    = byte_valid && advance;

    always_comb
    begin
        report = {pair, dec_reg};
    end

    always_comb
    begin
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        pending_next = pending_reg;
        dec_next     = dec_reg;
        if (byte_valid && rx_byte == ahkp_pkg::LineFeed)
        begin
            skip_next = 1'b0;
        end
        else if (counted)
        begin
            if (ahkp_pkg::is_first_of_pair(pos_reg))
            begin
                pending_next = rx_byte;
            end
            else if (slot < 3'(ahkp_pkg::StoredSlots))
            begin
                dec_next[slot] = pair;
            end
            if (emit)
            begin
                pos_next     = 5'd0;
                pending_next = 8'h00;
                dec_next     = '0;
                skip_next    = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            skip_reg    <= 1'b0;
            pending_reg <= 8'h00;
            dec_reg     <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            pending_reg <= pending_next;
            dec_reg     <= dec_next;
        end
    end

    // The count restarts when a report completes, so it never passes the last position.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ahkp_pkg::LastPos)
        else $error("character count beyond last report position");

    // A completed report always puts the parser into skip mode with a cleared count.
    a_emit_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (skip_reg && pos_reg == 5'd0))
        else $error("skip mode not entered after a completed report");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the hex key report parser: directed and random text report lines.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // This class predicts the seven report bytes from every accepted request and checks
    // each result that the block hands over against the oldest prediction.
    class key_report_tracker;
        logic [4:0]         position;
        logic               skipping;
        ahkp_pkg::byte_t    high_char;
        ahkp_pkg::report_t  partial;
        ahkp_pkg::report_t  pending_reports[$];
        int                 errors;
        int                 accepted;

        function new();
            position  = '0;
            skipping  = 1'b0;
            high_char = '0;
            partial   = '0;
            errors    = 0;
            accepted  = 0;
        endfunction

        // Returns the digit value in bits 3:0, with bit 4 set for a character that is not hex.
        function logic [4:0] digit_of(ahkp_pkg::byte_t c);
            logic [4:0] d;
            d = 5'h10;
            if (c inside {[8'h30:8'h39]})
            begin
                d = 5'(c - 8'h30);
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                d = 5'(c - 8'h41 + 8'd10);
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                d = 5'(c - 8'h61 + 8'd10);
            end
            return d;
        endfunction

        function ahkp_pkg::byte_t decode_pair(ahkp_pkg::byte_t hi, ahkp_pkg::byte_t lo);
            logic [4:0] dh;
            logic [4:0] dl;
            dh = digit_of(hi);
            dl = digit_of(lo);
            if (dh[4])
            begin
                return 8'h00;
            end
            if (dl[4])
            begin
                return {4'h0, dh[3:0]};
            end
            return {dh[3:0], dl[3:0]};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function int outstanding();
            return pending_reports.size();
        endfunction

        // Advances the prediction by one accepted character.
        function void note_request(ahkp_pkg::byte_t c);
            int p;
            accepted++;
            if (c == ahkp_pkg::LineFeed)
            begin
                skipping = 1'b0;
                return;
            end
            if (c == ahkp_pkg::CarriageReturn || skipping)
            begin
                return;
            end
            p = int'(position);
            if (p == 0 || (p >= 6 && p <= 21 && (p - 6) % 3 == 0))
            begin
                high_char = c;
            end
            else if (p == 1)
            begin
                partial[0] = decode_pair(high_char, c);
            end
            else if (p >= 7 && p <= 22 && (p - 7) % 3 == 0)
            begin
                partial[1 + (p - 7) / 3] = decode_pair(high_char, c);
            end
            position = position + 5'd1;
            if (position == ahkp_pkg::LastPos + 5'd1)
            begin
                pending_reports.push_back(partial);
                position  = '0;
                high_char = '0;
                partial   = '0;
                skipping  = 1'b1;
            end
        endfunction

        task check_result(ahkp_pkg::report_t got);
            ahkp_pkg::report_t want;
            string             field;
            if (pending_reports.size() == 0)
            begin
                report($sformatf("result %h arrived with no report pending", got));
                return;
            end
            want = pending_reports.pop_front();
            for (int i = 0; i < ahkp_pkg::SlotCount; i++)
            begin
                if (got[i] !== want[i])
                begin
                    field = (i == 0) ? "modifier_bits" : $sformatf("key_slot_%0d", i - 1);
                    report($sformatf("%s is %h, expected %h", field, got[i], want[i]));
                end
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;

    key_report_tracker tracker = new();

    // While a calm stretch lasts, the sending side never idles and the result side starts no new stall.
    bit send_calm  = 1'b0;
    bit stall_calm = 1'b0;

    ascii_hex_key_report_parser u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .modifier_bits (modifier_bits),
        .key_slot_0    (key_slot_0),
        .key_slot_1    (key_slot_1),
        .key_slot_2    (key_slot_2),
        .key_slot_3    (key_slot_3),
        .key_slot_4    (key_slot_4),
        .key_slot_5    (key_slot_5)
    );

    always #10 clk = ~clk;

    // Idle lengths come from three ranges: the shortest range most often, the longest range least often.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 40);
    endfunction

    // Offers one character and waits until the block takes it. The valid flag is lowered
    // only when a gap precedes this request, so that back-to-back requests keep it high.
    task automatic push_byte(input ahkp_pkg::byte_t b);
        int gap;
        if ($urandom_range(0, 79) == 0)
        begin
            send_calm = ~send_calm;
        end
        gap = (send_calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.note_request(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endtask

    function automatic ahkp_pkg::byte_t hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // A character that may break a pair or a separator: a neighbor of the hex ranges or
    // any byte at all, but never a carriage return or a line feed.
    function automatic ahkp_pkg::byte_t odd_char();
        string           edges;
        ahkp_pkg::byte_t c;
        edges = "/:@G`g -";
        if ($urandom_range(0, 1) == 0)
        begin
            return edges[$urandom_range(0, 7)];
        end
        c = 8'($urandom_range(0, 255));
        while (c == ahkp_pkg::LineFeed || c == ahkp_pkg::CarriageReturn)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // One line in the report format, with random content and the odd flaw.
    task automatic send_report_line(input int length);
        bit sep;
        int r;
        for (int p = 0; p < length; p++)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                push_byte(ahkp_pkg::CarriageReturn);
            end
            if ($urandom_range(0, 99) < 2)
            begin
                push_byte(ahkp_pkg::LineFeed);
            end
            sep = (p == 2) || (p >= 5 && (p - 5) % 3 == 0);
            if (sep)
            begin
                push_byte(($urandom_range(0, 99) < 85) ? 8'h2D : odd_char());
            end
            else
            begin
                push_byte(($urandom_range(0, 99) < 90) ? hex_char() : odd_char());
            end
        end
        // Characters after a complete report are skipped up to the line feed.
        if (length == int'(ahkp_pkg::LastPos) + 1 && $urandom_range(0, 99) < 30)
        begin
            repeat ($urandom_range(1, 4)) push_byte(odd_char());
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            push_byte(ahkp_pkg::CarriageReturn);
            push_byte(ahkp_pkg::LineFeed);
        end
        else if (r < 90)
        begin
            push_byte(ahkp_pkg::LineFeed);
        end
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
        begin
            push_byte(ahkp_pkg::LineFeed);
        end
    endtask

    // Result side: takes results when not stalled and stalls in stretches of random length.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.check_result({key_slot_5, key_slot_4, key_slot_3, key_slot_2,
                                      key_slot_1, key_slot_0, modifier_bits});
            end
            if ($urandom_range(0, 199) == 0)
            begin
                stall_calm = ~stall_calm;
            end
            if (stall_left == 0 && !stall_calm && $urandom_range(0, 99) < 30)
            begin
                stall_left = idle_length();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed line: mixed-case modifier, extreme bytes at ignored positions, a carriage
        // return and a line feed inside the line, a pair whose second character is not hex,
        // a pair whose first character is not hex, and neighbors of the digit ranges.
        push_text("Ff-");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ahkp_pkg::CarriageReturn);
        push_text("-00-7z-g5");
        push_byte(ahkp_pkg::LineFeed);
        push_text("-a0-9F-/:");
        // Skip mode after the report swallows these until the line feed.
        push_text("@G0");
        push_byte(ahkp_pkg::LineFeed);

        while (tracker.accepted < 1050)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                send_report_line(int'(ahkp_pkg::LastPos) + 1);
            end
            else if (kind < 90)
            begin
                send_noise_line();
            end
            else
            begin
                send_report_line($urandom_range(1, int'(ahkp_pkg::LastPos)));
            end
        end
        in_valid <= 1'b0;

        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ahkp_pkg.sv
hdl/ahkp_core.sv
hdl/ascii_hex_key_report_parser.sv
test/testbench.sv
